[hw/rtl/prd_pkg.sv]
package prd_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS    = 6;
  localparam int DEG_FRAC     = 16;
  localparam int ANG_SHIFT    = DEG_FRAC - FRAC_BITS;
  localparam int FULL_DEG     = 360 << FRAC_BITS;
  localparam int QUARTER_DEG  = 90 << FRAC_BITS;
  localparam int ANG_W        = $clog2(FULL_DEG);
  localparam int R_W          = $clog2(QUARTER_DEG);

  // CORDIC datapath
  localparam int CORDIC_ITERS = 20;
  localparam int Z_W          = 24;
  localparam int VEC_W        = 32;
  localparam int VEC_FRAC     = 30;
  localparam logic signed [VEC_W-1:0] INV_GAIN = 32'sd652032874;

  // Delay of prd_sincos from an accepted angle to registered cos/sin
  localparam int SINCOS_LAT   = CORDIC_ITERS + 3;

  // Field and stream widths
  localparam int IN_W         = 16;
  localparam int OUT_W        = 17;
  localparam int PROD_W       = IN_W + VEC_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 24'sd2949120;
      1:       v = 24'sd1740967;
      2:       v = 24'sd919879;
      3:       v = 24'sd466945;
      4:       v = 24'sd234379;
      5:       v = 24'sd117304;
      6:       v = 24'sd58666;
      7:       v = 24'sd29335;
      8:       v = 24'sd14668;
      9:       v = 24'sd7334;
      10:      v = 24'sd3667;
      11:      v = 24'sd1833;
      12:      v = 24'sd917;
      13:      v = 24'sd458;
      14:      v = 24'sd229;
      15:      v = 24'sd115;
      16:      v = 24'sd57;
      17:      v = 24'sd29;
      18:      v = 24'sd14;
      19:      v = 24'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/prd_sincos.sv]
module prd_sincos (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [prd_pkg::IN_W-1:0]       angle,
  output logic                                  out_valid,
  output logic signed [prd_pkg::VEC_W-1:0]      cos_o,
  output logic signed [prd_pkg::VEC_W-1:0]      sin_o
);

  localparam int NI    = prd_pkg::CORDIC_ITERS;
  localparam int VW    = prd_pkg::VEC_W;
  localparam int ZW    = prd_pkg::Z_W;
  localparam int AW    = prd_pkg::ANG_W;
  localparam int RW    = prd_pkg::R_W;
  localparam int EXT_W = prd_pkg::IN_W + 2;

  localparam logic signed [EXT_W-1:0] FULL_S = EXT_W'(prd_pkg::FULL_DEG);
  localparam logic [AW-1:0] Q1 = AW'(prd_pkg::QUARTER_DEG);
  localparam logic [AW-1:0] Q2 = AW'(2 * prd_pkg::QUARTER_DEG);
  localparam logic [AW-1:0] Q3 = AW'(3 * prd_pkg::QUARTER_DEG);

  // Stage A: wrap angle into [0, 360)
  logic signed [EXT_W-1:0] ang_ext;
  logic signed [EXT_W-1:0] ang_wrap;
  logic [AW-1:0]           a_r, a_nxt;
  logic                    va_r;

  always_comb begin
    ang_ext = {{2{angle[prd_pkg::IN_W-1]}}, angle};
    if (ang_ext >= FULL_S) begin
      ang_wrap = ang_ext - FULL_S;
    end else if (ang_ext >= 0) begin
      ang_wrap = ang_ext;
    end else if (ang_ext >= -FULL_S) begin
      ang_wrap = ang_ext + FULL_S;
    end else begin
      ang_wrap = ang_ext + (FULL_S <<< 1);
    end
    a_nxt = ang_wrap[AW-1:0];
  end

  // Stage B: quadrant split, residual scaled to 2^-16 degree
  prd_pkg::quad_t          qb_r, qb_nxt;
  logic [AW-1:0]           rem_full;
  logic [RW-1:0]           r_q;
  logic signed [ZW-1:0]    zb_r, zb_nxt;
  logic                    vb_r;

  always_comb begin
    if (a_r >= Q3) begin
      qb_nxt   = prd_pkg::QUAD_3;
      rem_full = a_r - Q3;
    end else if (a_r >= Q2) begin
      qb_nxt   = prd_pkg::QUAD_2;
      rem_full = a_r - Q2;
    end else if (a_r >= Q1) begin
      qb_nxt   = prd_pkg::QUAD_1;
      rem_full = a_r - Q1;
    end else begin
      qb_nxt   = prd_pkg::QUAD_0;
      rem_full = a_r;
    end
    r_q    = rem_full[RW-1:0];
    zb_nxt = $signed(ZW'(r_q) << prd_pkg::ANG_SHIFT);
  end

  // CORDIC micro-rotations, one per stage
  logic signed [VW-1:0]  cx_r   [NI];
  logic signed [VW-1:0]  cy_r   [NI];
  logic signed [ZW-1:0]  cz_r   [NI];
  logic signed [VW-1:0]  cx_nxt [NI];
  logic signed [VW-1:0]  cy_nxt [NI];
  logic signed [ZW-1:0]  cz_nxt [NI];
  logic signed [VW-1:0]  cx_in  [NI];
  logic signed [VW-1:0]  cy_in  [NI];
  logic signed [ZW-1:0]  cz_in  [NI];
  prd_pkg::quad_t        cq_r   [NI];
  logic [NI-1:0]         cv_r;

  always_comb begin
    cx_in[0] = prd_pkg::INV_GAIN;
    cy_in[0] = '0;
    cz_in[0] = zb_r;
    for (int i = 1; i < NI; i++) begin
      cx_in[i] = cx_r[i-1];
      cy_in[i] = cy_r[i-1];
      cz_in[i] = cz_r[i-1];
    end
    for (int i = 0; i < NI; i++) begin
      if (!cz_in[i][ZW-1]) begin
        cx_nxt[i] = cx_in[i] - (cy_in[i] >>> i);
        cy_nxt[i] = cy_in[i] + (cx_in[i] >>> i);
        cz_nxt[i] = cz_in[i] - prd_pkg::atan_deg(i);
      end else begin
        cx_nxt[i] = cx_in[i] + (cy_in[i] >>> i);
        cy_nxt[i] = cy_in[i] - (cx_in[i] >>> i);
        cz_nxt[i] = cz_in[i] + prd_pkg::atan_deg(i);
      end
    end
  end

  // Quadrant fold
  logic signed [VW-1:0] xl, yl;
  logic signed [VW-1:0] cos_r, cos_nxt;
  logic signed [VW-1:0] sin_r, sin_nxt;
  logic                 vf_r;

  always_comb begin
    xl = cx_r[NI-1];
    yl = cy_r[NI-1];
    case (cq_r[NI-1])
      prd_pkg::QUAD_1: begin
        cos_nxt = -yl;
        sin_nxt = xl;
      end
      prd_pkg::QUAD_2: begin
        cos_nxt = -xl;
        sin_nxt = -yl;
      end
      prd_pkg::QUAD_3: begin
        cos_nxt = yl;
        sin_nxt = -xl;
      end
      default: begin
        cos_nxt = xl;
        sin_nxt = yl;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      cv_r <= '0;
      vf_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      cv_r <= {cv_r[NI-2:0], vb_r};
      vf_r <= cv_r[NI-1];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      qb_r <= qb_nxt;
      zb_r <= zb_nxt;
      cq_r[0] <= qb_r;
      for (int i = 1; i < NI; i++) begin
        cq_r[i] <= cq_r[i-1];
      end
      for (int i = 0; i < NI; i++) begin
        cx_r[i] <= cx_nxt[i];
        cy_r[i] <= cy_nxt[i];
        cz_r[i] <= cz_nxt[i];
      end
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_valid = vf_r;
  assign cos_o     = cos_r;
  assign sin_o     = sin_r;

endmodule

[hw/rtl/point_rotation_by_degrees_top.sv]
// Point rotator: turns (x, y) counter-clockwise about the origin by an angle
// in degrees. All fields are signed with 6 fractional bits.
//
// Input stream: in_tvalid / in_tready / in_tdata carry one point and its
// angle per item. The angle is wrapped modulo 360 degrees internally.
// Result stream: out_tvalid / out_tready / out_tdata carry the rotated point,
// rounded to nearest, one result per input item, in input order.
//
// Pipeline: 2 angle-reduce stages, 20 CORDIC stages, quadrant fold,
// multiply, sum/round, output reg. Throughput: one item per cycle while
// in_tready is high; every stage is registered and the 20-stage CORDIC
// pipeline holds one micro-rotation per stage.
//
// Reset (rst_n low, synchronous) empties the pipeline and the output side.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register; in_tready then drops and the whole
// pipeline freezes in place until the skid drains.
module point_rotation_by_degrees_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] x_in, [31:16] y_in, [47:32] angle_deg
  input  logic [prd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] x_out, [33:17] y_out, [39:34] zero
  output logic [prd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int IW   = prd_pkg::IN_W;
  localparam int OW   = prd_pkg::OUT_W;
  localparam int VW   = prd_pkg::VEC_W;
  localparam int PW   = prd_pkg::PROD_W;
  localparam int SW   = prd_pkg::SUM_W;
  localparam int LAT  = prd_pkg::SINCOS_LAT;
  localparam int FR   = prd_pkg::VEC_FRAC;
  localparam int DW   = 2 * OW;

  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FR - 1);

  logic en;
  logic signed [IW-1:0] x_in, y_in, angle_deg;

  assign x_in      = $signed(in_tdata[IW-1:0]);
  assign y_in      = $signed(in_tdata[2*IW-1:IW]);
  assign angle_deg = $signed(in_tdata[3*IW-1:2*IW]);

  // Sine / cosine pipeline
  logic                 sc_valid;
  logic signed [VW-1:0] sc_cos, sc_sin;

  prd_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .angle     (angle_deg),
    .out_valid (sc_valid),
    .cos_o     (sc_cos),
    .sin_o     (sc_sin)
  );

  // Point delay line matched to the sine / cosine latency
  logic signed [IW-1:0] xd_r [LAT];
  logic signed [IW-1:0] yd_r [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0] <= x_in;
      yd_r[0] <= y_in;
      for (int i = 1; i < LAT; i++) begin
        xd_r[i] <= xd_r[i-1];
        yd_r[i] <= yd_r[i-1];
      end
    end
  end

  // Products stage
  logic signed [PW-1:0] xc_r, ys_r, xs_r, yc_r;
  logic                 pv_r;

  // Sum and round-bias stage
  logic signed [SW-1:0] xsum_r, ysum_r;
  logic                 sv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xc_r   <= PW'(xd_r[LAT-1]) * PW'(sc_cos);
      ys_r   <= PW'(yd_r[LAT-1]) * PW'(sc_sin);
      xs_r   <= PW'(xd_r[LAT-1]) * PW'(sc_sin);
      yc_r   <= PW'(yd_r[LAT-1]) * PW'(sc_cos);
      xsum_r <= SW'(xc_r) - SW'(ys_r) + HALF;
      ysum_r <= SW'(xs_r) + SW'(yc_r) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sc_valid;
      sv_r <= pv_r;
    end
  end

  // Rounded result: floor shift of the biased sums
  logic [DW-1:0] res_item;
  assign res_item = {ysum_r[FR+OW-1:FR], xsum_r[FR+OW-1:FR]};

  // Output register with skid
  logic          out_valid_r, skid_valid_r;
  logic [DW-1:0] out_data_r, skid_data_r;
  logic          take;

  assign en   = !skid_valid_r;
  assign take = en && sv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (take) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= res_item;
      end else begin
        skid_data_r <= res_item;
      end
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(prd_pkg::OUT_TDATA_W - DW){1'b0}}, out_data_r};

endmodule

[hw/rtl/prd_checker.sv]
module prd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [prd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [prd_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Reset empties the result side
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Input side only backs up while a result is waiting
  a_ready_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with no pending result");

  // Ready drops only after a stalled result
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("in_tready fell without an output stall");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind point_rotation_by_degrees_top prd_checker u_prd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[bench/tb_point_rotation_by_degrees_top.sv]
`timescale 1ns / 1ps

module tb_point_rotation_by_degrees_top;

  localparam int PHASE_ITEMS  = 175;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIR        = 22;

  // Rotated point as it travels on out_tdata
  typedef struct packed {
    logic signed [prd_pkg::OUT_W-1:0] y;
    logic signed [prd_pkg::OUT_W-1:0] x;
  } point_t;

  // One directed stimulus row; res is used only when known is set
  typedef struct packed {
    logic signed [prd_pkg::IN_W-1:0] x;
    logic signed [prd_pkg::IN_W-1:0] y;
    logic signed [prd_pkg::IN_W-1:0] ang;
    logic                            known;
    point_t                          res;
  } dir_row_t;

  localparam point_t ZERO_PT = '0;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  // [15:0] x_in, [31:16] y_in, [47:32] angle_deg
  logic [prd_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [16:0] x_out, [33:17] y_out, [39:34] zero
  logic [prd_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Sideband travelling with in_tdata: typed-in result for directed rows
  logic   row_known = 1'b0;
  point_t row_res   = '0;

  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  int     err_count     = 0;
  int     cycle_count   = 0;
  point_t rotated_q [$];

  // atan(2^-i) in degrees, 16 fractional bits
  longint atan_q16 [prd_pkg::CORDIC_ITERS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  dir_row_t dir_rows [N_DIR] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, ZERO_PT},
    '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, ZERO_PT},
    '{16'sd0,      16'sd0,      16'sd32767,  1'b1, ZERO_PT},
    '{16'sd32767,  16'sd0,      16'sd0,      1'b0, ZERO_PT},
    '{-16'sd32768, 16'sd0,      16'sd0,      1'b0, ZERO_PT},
    '{16'sd0,      16'sd32767,  16'sd0,      1'b0, ZERO_PT},
    '{16'sd0,      -16'sd32768, 16'sd5760,   1'b0, ZERO_PT},
    '{16'sd32767,  16'sd32767,  16'sd2880,   1'b0, ZERO_PT},
    '{-16'sd32768, -16'sd32768, 16'sd2880,   1'b0, ZERO_PT},
    '{-16'sd32768, 16'sd32767,  16'sd8640,   1'b0, ZERO_PT},
    '{16'sd32767,  -16'sd32768, 16'sd14400,  1'b0, ZERO_PT},
    '{16'sd1,      16'sd0,      16'sd11520,  1'b0, ZERO_PT},
    '{-16'sd1,     -16'sd1,     16'sd17280,  1'b0, ZERO_PT},
    '{16'sd100,    -16'sd200,   16'sd23039,  1'b0, ZERO_PT},
    '{16'sd100,    -16'sd200,   16'sd23040,  1'b0, ZERO_PT},
    '{16'sd100,    -16'sd200,   -16'sd1,     1'b0, ZERO_PT},
    '{16'sd12345,  -16'sd4321,  -16'sd5760,  1'b0, ZERO_PT},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, ZERO_PT},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, ZERO_PT},
    '{16'sd64,     16'sd0,      16'sd5759,   1'b0, ZERO_PT},
    '{16'sd64,     16'sd0,      16'sd5761,   1'b0, ZERO_PT},
    '{-16'sd7,     16'sd3,      16'sd20000,  1'b0, ZERO_PT}
  };

  int idle_tab  [4] = '{0, 69, 0, 21};
  int stall_tab [4] = '{0, 0, 69, 21};

  point_rotation_by_degrees_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rotate (px, py) by pa degrees: wrap angle, CORDIC for cos/sin, fold, round
  function automatic point_t rotate_point(input logic signed [prd_pkg::IN_W-1:0] px,
                                          input logic signed [prd_pkg::IN_W-1:0] py,
                                          input logic signed [prd_pkg::IN_W-1:0] pa);
    longint a, q, r, vx, vy, z, dx, dy, c, s, xr, yr, half;
    point_t res;
    a = longint'(pa) % prd_pkg::FULL_DEG;
    if (a < 0) a = a + prd_pkg::FULL_DEG;
    q = a / prd_pkg::QUARTER_DEG;
    r = a - q * prd_pkg::QUARTER_DEG;
    vx = prd_pkg::INV_GAIN;
    vy = 0;
    z  = r * (longint'(1) <<< prd_pkg::ANG_SHIFT);
    for (int i = 0; i < prd_pkg::CORDIC_ITERS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (z >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - atan_q16[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + atan_q16[i];
      end
    end
    case (prd_pkg::quad_t'(q[1:0]))
      prd_pkg::QUAD_1: begin
        c = -vy;
        s = vx;
      end
      prd_pkg::QUAD_2: begin
        c = -vx;
        s = -vy;
      end
      prd_pkg::QUAD_3: begin
        c = vy;
        s = -vx;
      end
      default: begin
        c = vx;
        s = vy;
      end
    endcase
    // drop Q30 fraction, round half toward +inf
    half = longint'(1) <<< (prd_pkg::VEC_FRAC - 1);
    xr = (longint'(px) * c - longint'(py) * s + half) >>> prd_pkg::VEC_FRAC;
    yr = (longint'(px) * s + longint'(py) * c + half) >>> prd_pkg::VEC_FRAC;
    res.x = xr[prd_pkg::OUT_W-1:0];
    res.y = yr[prd_pkg::OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // Present one item, idling first at the current sender rate
  task automatic send_point(input logic signed [prd_pkg::IN_W-1:0] px,
                            input logic signed [prd_pkg::IN_W-1:0] py,
                            input logic signed [prd_pkg::IN_W-1:0] pa,
                            input logic known, input point_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pa, py, px};
    row_known <= known;
    row_res   <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [prd_pkg::IN_W-1:0] edge_value();
    case ($urandom_range(5))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      4:       return 16'sd1;
      default: return prd_pkg::IN_W'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic signed [prd_pkg::IN_W-1:0] px, py, pa;
    int sel;
    sel = $urandom_range(9);
    px  = prd_pkg::IN_W'($urandom);
    py  = prd_pkg::IN_W'($urandom);
    pa  = prd_pkg::IN_W'($urandom);
    if (sel >= 8) begin
      px = edge_value();
      py = edge_value();
    end else if (sel >= 6) begin
      // near a quadrant boundary, positive or negative turns
      pa = prd_pkg::IN_W'(($signed($urandom_range(10)) - 5) * prd_pkg::QUARTER_DEG
                          + $signed($urandom_range(4)) - 2);
    end
    send_point(px, py, pa, 1'b0, ZERO_PT);
  endtask

  // Receiver readiness
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_point_rotation_by_degrees_top failed");
      $finish;
    end
  end

  // Record accepted items and check results in order
  always @(posedge clk) begin : check_blk
    point_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (row_known)
          rotated_q.push_back(row_res);
        else
          rotated_q.push_back(rotate_point(in_tdata[15:0], in_tdata[31:16],
                                           in_tdata[47:32]));
      end
      if (out_tvalid && out_tready) begin
        if (rotated_q.size() == 0) begin
          report_mismatch("unexpected result", longint'(out_tdata), 0);
        end else begin
          want = rotated_q.pop_front();
          if (out_tdata[16:0] !== want.x)
            report_mismatch("x_out", $signed(out_tdata[16:0]), want.x);
          if (out_tdata[33:17] !== want.y)
            report_mismatch("y_out", $signed(out_tdata[33:17]), want.y);
          if (out_tdata[39:34] !== 6'd0)
            report_mismatch("pad", out_tdata[39:34], 0);
        end
      end
    end
  end

  // Stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].ang,
                 dir_rows[i].known, dir_rows[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) wait_drained();
      send_idle_pct = idle_tab[ph];
      stall_pct    <= stall_tab[ph];
      repeat (PHASE_ITEMS) send_random();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && rotated_q.size() == 0)
      $display("tb_point_rotation_by_degrees_top passed");
    else
      $display("tb_point_rotation_by_degrees_top failed");
    $finish;
  end

endmodule
